@@ sv/pltiu_pkg.sv @@
package pltiu_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int ValW       = 20;
  localparam int CntW       = 6;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic CFG_FORWARD = 1'b0;
  localparam logic CFG_INVERSE = 1'b1;

  typedef struct packed {
    logic            action;
    logic            direction;
    logic [4:0]      entry_index;
    logic [ValW-1:0] entry_key;
    logic [ValW-1:0] entry_value;
    logic [ValW-1:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] result_value;
    logic            clamped;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic            capture;   // latch input beat
    logic            rd_en;     // issue table read
    logic [IdxW-1:0] rd_addr;
    logic            chk_first; // compare read entry as first key
    logic            chk_last;  // compare read entry as last key
    logic            ld_k1;     // keep read entry as upper neighbor
    logic            ld_k0;     // keep read entry as lower neighbor
    logic            mul;       // form value step
    logic            prod;      // form offset times value step
    logic            div_start;
    logic            finish;    // build result
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic done_early;  // first/last check resolved result
    logic scan_hit;    // scanned key at or above query
    logic div_busy;
  } sts_t;

endpackage

@@ sv/pltiu_datapath.sv @@
module pltiu_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pltiu_pkg::in_item_t  in_item,
  input  pltiu_pkg::cmd_t      cmd,
  output pltiu_pkg::sts_t      sts,
  output pltiu_pkg::out_item_t res
);
  import pltiu_pkg::*;

  logic [2*ValW-1:0] fwd_mem [TableDepth];
  logic [2*ValW-1:0] inv_mem [TableDepth];
  logic [2*ValW-1:0] rd_r;

  in_item_t          item_r;
  logic [ValW-1:0]   k0_r, k1_r, v0_r, v1_r;
  logic [ValW-1:0]   rk, rv;
  logic              early_r;
  logic [ValW-1:0]   early_val_r;
  logic              early_cl_r;
  logic signed [ValW+1:0]   dv_r;
  logic signed [2*ValW+2:0] prod_r;
  logic              neg_r;
  logic [2*ValW+1:0] num_r;
  logic [ValW-1:0]   den_r;
  logic [2*ValW+1:0] quo_r;
  logic [ValW:0]     rem_r;
  logic [5:0]        dcnt_r;
  logic              busy_r;
  out_item_t         res_r;

  assign rk = rd_r[2*ValW-1:ValW];
  assign rv = rd_r[ValW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture && in_item.action == ACT_LOAD) begin
      if (in_item.direction == CFG_INVERSE) begin
        inv_mem[in_item.entry_index[IdxW-1:0]] <= {in_item.entry_key, in_item.entry_value};
      end else begin
        fwd_mem[in_item.entry_index[IdxW-1:0]] <= {in_item.entry_key, in_item.entry_value};
      end
    end
    if (cmd.rd_en) begin
      rd_r <= (item_r.direction == CFG_INVERSE) ? inv_mem[cmd.rd_addr] : fwd_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r  <= in_item;
      early_r <= 1'b0;
    end
    if (cmd.chk_first && item_r.query_value <= rk) begin
      early_r     <= 1'b1;
      early_val_r <= rv;
      early_cl_r  <= item_r.query_value < rk;
    end
    if (cmd.chk_last && !early_r && item_r.query_value >= rk) begin
      early_r     <= 1'b1;
      early_val_r <= rv;
      early_cl_r  <= item_r.query_value > rk;
    end
    if (cmd.ld_k1) begin
      k1_r <= rk;
      v1_r <= rv;
    end
    if (cmd.ld_k0) begin
      k0_r <= rk;
      v0_r <= rv;
    end
    if (cmd.mul) begin
      dv_r <= $signed({2'b00, v1_r}) - $signed({2'b00, v0_r});
    end
  end

  // Restoring divider: one quotient bit per cycle over the magnitude.
  logic [ValW+1:0] trial;
  logic [2*ValW+2:0] mag;
  always_comb begin
    trial = {rem_r, num_r[2*ValW+1]} - {2'b00, den_r};
    mag   = prod_r[2*ValW+2] ? -prod_r : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      dcnt_r <= 6'(2*ValW+2);
      neg_r  <= prod_r[2*ValW+2];
      num_r  <= mag[2*ValW+1:0];
      den_r  <= k1_r - k0_r;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      if (!trial[ValW+1]) begin
        rem_r <= trial[ValW:0];
        quo_r <= {quo_r[2*ValW:0], 1'b1};
      end else begin
        rem_r <= {rem_r[ValW-1:0], num_r[2*ValW+1]};
        quo_r <= {quo_r[2*ValW:0], 1'b0};
      end
      num_r  <= {num_r[2*ValW:0], 1'b0};
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  // Product registered in the cycle after dv_r.
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prod_r <= $signed({3'b000, item_r.query_value - k0_r}) * dv_r;
    end
  end

  logic signed [2*ValW+3:0] sum;
  logic [ValW:0]            mean;
  always_comb begin
    mean = ({1'b0, v0_r} + {1'b0, v1_r}) >> 1;
    sum  = $signed({4'b0000, v0_r}) +
           (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}));
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (early_r) begin
        res_r.result_value <= early_val_r;
        res_r.clamped      <= early_cl_r;
      end else begin
        res_r.clamped <= 1'b0;
        if (k1_r == k0_r) res_r.result_value <= mean[ValW-1:0];
        else if (sum < 0) res_r.result_value <= '0;
        else if (sum > $signed({4'b0000, {ValW{1'b1}}})) res_r.result_value <= '1;
        else res_r.result_value <= sum[ValW-1:0];
      end
    end
  end

  assign res = res_r;
  assign sts.is_query   = item_r.action == ACT_QUERY;
  assign sts.done_early = early_r;
  assign sts.scan_hit   = rk >= item_r.query_value;
  assign sts.div_busy   = busy_r;

endmodule

@@ sv/pltiu_ctrl.sv @@
module pltiu_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          out_ready,
  input  logic [pltiu_pkg::CntW-1:0]    fwd_cnt,
  input  logic [pltiu_pkg::CntW-1:0]    inv_cnt,
  input  logic                          dir,
  input  pltiu_pkg::sts_t               sts,
  output pltiu_pkg::cmd_t               cmd,
  output logic                          idle,
  output logic                          out_valid
);
  import pltiu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_FIRST = 4'd2, S_LASTR = 4'd3,
                         S_LAST = 4'd4, S_SCAN = 4'd5, S_K0R = 4'd6, S_K0 = 4'd7,
                         S_DV = 4'd8, S_MUL = 4'd9, S_DIV = 4'd10, S_WAIT = 4'd11,
                         S_FIN = 4'd12, S_OUT = 4'd13;

  logic [3:0]      st_r, st_nxt;
  logic [IdxW-1:0] j_r, j_nxt, last;
  logic [CntW-1:0] n;

  always_comb begin
    n = dir ? inv_cnt : fwd_cnt;
    if (n == '0) last = '0;
    else if (n > CntW'(TableDepth)) last = IdxW'(TableDepth - 1);
    else last = IdxW'(n - 1'b1);
  end

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    j_nxt  = j_r;
    cmd.capture = in_fire;
    case (st_r)
      S_IDLE: if (in_fire) st_nxt = S_DEC;
      S_DEC: begin
        if (sts.is_query) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = '0; st_nxt = S_FIRST;
        end else st_nxt = S_IDLE;
      end
      S_FIRST: begin
        cmd.chk_first = 1'b1;
        cmd.rd_en = 1'b1; cmd.rd_addr = last; st_nxt = S_LASTR;
      end
      S_LASTR: begin
        cmd.chk_last = 1'b1; st_nxt = S_LAST;
      end
      S_LAST: begin
        if (sts.done_early) st_nxt = S_FIN;
        else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(1); j_nxt = IdxW'(1); st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit || j_r == last) begin
          cmd.ld_k1 = 1'b1; cmd.rd_en = 1'b1; cmd.rd_addr = j_r - 1'b1; st_nxt = S_K0R;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = j_r + 1'b1; j_nxt = j_r + 1'b1;
        end
      end
      S_K0R: st_nxt = S_K0;
      S_K0: begin cmd.ld_k0 = 1'b1; st_nxt = S_DV; end
      S_DV: begin cmd.mul = 1'b1; st_nxt = S_MUL; end
      S_MUL: begin cmd.prod = 1'b1; st_nxt = S_DIV; end
      S_DIV: begin cmd.div_start = 1'b1; st_nxt = S_WAIT; end
      S_WAIT: if (!sts.div_busy) st_nxt = S_FIN;
      S_FIN: begin cmd.finish = 1'b1; st_nxt = S_OUT; end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      j_r  <= '0;
    end else begin
      st_r <= st_nxt;
      j_r  <= j_nxt;
    end
  end

  assign idle      = st_r == S_IDLE;
  assign out_valid = st_r == S_OUT;

endmodule

@@ sv/piecewise_linear_table_interp_unit.sv @@
// Flow: a load writes its table entry as it is accepted; a query reads the first
//   and last entries and, when neither resolves it, scans keys at one table read
//   per cycle, then runs the one-bit-per-cycle 42-bit restoring divider.
// Occupancy: one item at a time; a new item is accepted only once the last one
//   is done and, for a query, its result has been taken.
// Reset: synchronous active-low rst_n; entry counts reset to 1, tables hold
//   whatever was last written.
module piecewise_linear_table_interp_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pltiu_pkg::in_item_t       in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pltiu_pkg::out_item_t      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [pltiu_pkg::CntW-1:0] cfg_data
);
  import pltiu_pkg::*;

  logic [CntW-1:0] fwd_cnt_r, inv_cnt_r;
  logic            in_fire, idle;
  cmd_t            cmd;
  sts_t            sts;
  logic            dir_hold_r;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = idle;

  // Hold config counts; write on each config beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_cnt_r <= CntW'(1);
      inv_cnt_r <= CntW'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INVERSE) inv_cnt_r <= cfg_data;
      else fwd_cnt_r <= cfg_data;
    end
  end

  // Keep direction of the item in flight for table count selection.
  always_ff @(posedge clk) begin
    if (in_fire) dir_hold_r <= in_data.direction;
  end

  pltiu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_ready(out_ready),
    .fwd_cnt(fwd_cnt_r), .inv_cnt(inv_cnt_r), .dir(dir_hold_r),
    .sts(sts), .cmd(cmd), .idle(idle), .out_valid(out_valid)
  );

  pltiu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .sts(sts), .res(out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !out_valid) else $error("result during divide");
`endif

endmodule
